// ----- rtl/qsce_pkg.sv -----
// Shared types, constants and the swap/place micro-program of the queen swap conflict engine.
`default_nettype none
package qsce_pkg;

    localparam int MAX_QUEENS_DEF = 1024;

    localparam int BOARD_W = 11;
    localparam int INDEX_W = 10;
    localparam int COORD_W = 10;
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 12;
    localparam int TOT_W   = 13;
    localparam int FREE_W  = 13;
    localparam int CONF_W  = 11;
    localparam int STEP_W  = 5;

    localparam logic [BOARD_W-1:0] BOARD_RESET = 11'd8;
    localparam logic [FREE_W-1:0]  FREE_RESET  = 13'd30;
    localparam logic [CONF_W-1:0]  CONF_SAT    = 11'd2046;

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_PLACE = 2'd1;
    localparam logic [1:0] FN_SWAP  = 2'd2;
    localparam logic [1:0] FN_NOP   = 2'd3;

    localparam logic [STEP_W-1:0] PLACE_LAST = 5'd3;
    localparam logic [STEP_W-1:0] SWAP_DEC   = 5'd15;
    localparam logic [STEP_W-1:0] SWAP_LAST  = 5'd25;

    typedef struct packed {
        logic [1:0]         func;
        logic [INDEX_W-1:0] index_a;
        logic [INDEX_W-1:0] index_b;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_in_beat;

    typedef struct packed {
        logic              accepted;
        logic [CONF_W-1:0] conflicts_a;
        logic              solved;
        logic              error;
    } t_out_beat;

    // read first diagonal, read second and finish, decrement, increment
    typedef enum logic [1:0] {K_RDF, K_RDL, K_DN, K_UP} t_kind;
    // A, B original; AS, BS with rows exchanged
    typedef enum logic [1:0] {P_A, P_B, P_AS, P_BS} t_pt;

    typedef struct packed {
        t_kind kind;
        t_pt   pt;
        logic  rise;
        logic  cap_a;
        logic  tot_clr;
    } t_uop;

    typedef struct packed {
        logic load_in;
        logic q_rd;
        logic q_sel_b;
        logic q_cap_a;
        logic q_cap_b;
        logic place_wr;
        logic row_wr_a;
        logic row_wr_b;
        logic sweep;
        logic free_load;
        logic uop_rd;
        logic uop_ex;
        t_uop uop;
        logic set_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       sweep_last;
        logic       revert;
        logic       out_free;
    } t_stat;

    function automatic t_uop uop_get(input logic swap, input logic [STEP_W-1:0] step);
        t_uop u;
        u.rise    = step[0];
        u.cap_a   = 1'b0;
        u.tot_clr = 1'b0;
        u.kind    = K_RDF;
        u.pt      = P_A;
        if (!swap) begin
            u.kind  = (step[1] == 1'b0) ? K_UP : (step[0] ? K_RDL : K_RDF);
            u.cap_a = (step == PLACE_LAST);
        end else begin
            u.cap_a   = (step == 5'd1) || (step == 5'd13) || (step == 5'd25);
            u.tot_clr = (step == 5'd0) || (step == 5'd12) || (step == 5'd24);
            case (step[4:1])
                4'd0: begin u.kind = step[0] ? K_RDL : K_RDF; u.pt = P_A;  end
                4'd1: begin u.kind = step[0] ? K_RDL : K_RDF; u.pt = P_B;  end
                4'd2: begin u.kind = K_DN; u.pt = P_A;  end
                4'd3: begin u.kind = K_DN; u.pt = P_B;  end
                4'd4: begin u.kind = K_UP; u.pt = P_AS; end
                4'd5: begin u.kind = K_UP; u.pt = P_BS; end
                4'd6: begin u.kind = step[0] ? K_RDL : K_RDF; u.pt = P_AS; end
                4'd7: begin u.kind = step[0] ? K_RDL : K_RDF; u.pt = P_BS; end
                4'd8: begin u.kind = K_DN; u.pt = P_AS; end
                4'd9: begin u.kind = K_DN; u.pt = P_BS; end
                4'd10: begin u.kind = K_UP; u.pt = P_A;  end
                4'd11: begin u.kind = K_UP; u.pt = P_B;  end
                4'd12: begin u.kind = step[0] ? K_RDL : K_RDF; u.pt = P_A; end
                default: begin u.kind = K_RDF; u.pt = P_A; end
            endcase
        end
        return u;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qsce_dp.sv -----
// Datapath: board memories, diagonal counters, conflict arithmetic and output register.
`default_nettype none
module qsce_dp import qsce_pkg::*; #(
    parameter int MAX_QUEENS = MAX_QUEENS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_in_beat            i_in_data,
    input  wire                      i_cfg_we,
    input  wire logic [BOARD_W-1:0]  i_cfg_wdata,
    input  wire                      i_out_ready,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic                     o_out_valid,
    output t_out_beat                o_out_data
);

    localparam int QW    = $clog2(MAX_QUEENS);
    localparam int DW    = QW + 2;
    localparam int DIAGS = 4 * MAX_QUEENS;

    logic [COORD_W-1:0] mem_col  [0:MAX_QUEENS-1];
    logic [COORD_W-1:0] mem_row  [0:MAX_QUEENS-1];
    logic [COUNT_W-1:0] mem_diag [0:DIAGS-1];

    logic [BOARD_W-1:0] r_cfg;
    logic [FREE_W-1:0]  r_free;
    logic [DW-1:0]      r_sw;
    logic               r_oval;
    t_out_beat          r_out;

    logic [QW-1:0]      r_a, r_b;
    logic [COORD_W-1:0] r_col_a, r_row_a, r_col_b, r_row_b;
    logic [COORD_W-1:0] r_qc, r_qr;
    logic [COUNT_W-1:0] r_dq, r_accs;
    logic [TOT_W-1:0]   r_tot, r_before;
    logic [CONF_W-1:0]  r_ca;
    logic               r_err, r_acc;

    logic [31:0]        w_bs, w_n, w_ia, w_ib, w_fall, w_rise;
    logic [FREE_W-1:0]  w_full;
    logic [COORD_W-1:0] w_c, w_r;
    logic [DW-1:0]      w_daddr;
    logic [COUNT_W-1:0] w_cnt_new;
    logic [SUM_W-1:0]   w_s, w_conf;
    logic [QW-1:0]      w_qr_addr, w_qw_addr;
    logic [COORD_W-1:0] w_qw_row;
    logic               w_cnt_wr;

    assign w_bs   = 32'(r_cfg);
    assign w_n    = (w_bs < 32'd4) ? 32'd4 :
                    (w_bs > 32'(MAX_QUEENS)) ? 32'(MAX_QUEENS) : w_bs;
    assign w_full = FREE_W'(32'd4 * w_n - 32'd2);

    assign w_ia = 32'(i_in_data.index_a);
    assign w_ib = 32'(i_in_data.index_b);

    always_comb begin
        case (i_cmd.uop.pt)
            P_A:     begin w_c = r_col_a; w_r = r_row_a; end
            P_B:     begin w_c = r_col_b; w_r = r_row_b; end
            P_AS:    begin w_c = r_col_a; w_r = r_row_b; end
            P_BS:    begin w_c = r_col_b; w_r = r_row_a; end
            default: begin w_c = r_col_a; w_r = r_row_a; end
        endcase
    end

    assign w_fall  = w_n - 32'd1 + 32'(w_c) - 32'(w_r);
    assign w_rise  = 32'd2 * w_n - 32'd1 + 32'(w_c) + 32'(w_r);
    assign w_daddr = i_cmd.uop.rise ? w_rise[DW-1:0] : w_fall[DW-1:0];

    always_comb begin
        w_cnt_new = r_dq;
        w_cnt_wr  = 1'b0;
        case (i_cmd.uop.kind)
            K_UP: begin
                w_cnt_wr = 1'b1;
                if (r_dq != '1) w_cnt_new = r_dq + 1'b1;
            end
            K_DN: begin
                w_cnt_wr = 1'b1;
                if (r_dq != '0) w_cnt_new = r_dq - 1'b1;
            end
            default: begin
                w_cnt_wr = 1'b0;
            end
        endcase
    end

    assign w_s    = {1'b0, r_accs} + {1'b0, r_dq};
    assign w_conf = (w_s < 12'd2) ? '0 : w_s - 12'd2;

    assign w_qr_addr = i_cmd.q_sel_b ? r_b : r_a;
    assign w_qw_addr = i_cmd.row_wr_b ? r_b : r_a;
    assign w_qw_row  = i_cmd.place_wr ? r_row_a : (i_cmd.row_wr_a ? r_row_b : r_row_a);

    // board memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.place_wr) begin
            mem_col[r_a] <= r_col_a;
        end
        if (i_cmd.place_wr || i_cmd.row_wr_a || i_cmd.row_wr_b) begin
            mem_row[w_qw_addr] <= w_qw_row;
        end
        if (i_cmd.q_rd) begin
            r_qc <= mem_col[w_qr_addr];
            r_qr <= mem_row[w_qr_addr];
        end
    end

    // diagonal counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            mem_diag[r_sw] <= '0;
        end else if (i_cmd.uop_ex && w_cnt_wr) begin
            mem_diag[w_daddr] <= w_cnt_new;
        end
        if (i_cmd.uop_rd) begin
            r_dq <= mem_diag[w_daddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= BOARD_RESET;
            r_free <= FREE_RESET;
            r_sw   <= '0;
            r_oval <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (i_cmd.sweep) r_sw <= r_sw + 1'b1;
            if (i_cmd.free_load) begin
                r_free <= w_full;
            end else if (i_cmd.uop_ex && i_cmd.uop.kind == K_UP && r_dq == 11'd1) begin
                r_free <= r_free - 1'b1;
            end else if (i_cmd.uop_ex && i_cmd.uop.kind == K_DN && r_dq == 11'd2) begin
                r_free <= r_free + 1'b1;
            end
            if (i_cmd.out_load) r_oval <= 1'b1;
            else if (i_out_ready) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a     <= w_ia[QW-1:0];
            r_b     <= w_ib[QW-1:0];
            r_col_a <= i_in_data.col;
            r_row_a <= i_in_data.row;
            r_err   <= 1'b0;
            r_ca    <= '0;
            r_acc   <= 1'b0;
        end
        if (i_cmd.q_cap_a) begin
            r_col_a <= r_qc;
            r_row_a <= r_qr;
        end
        if (i_cmd.q_cap_b) begin
            r_col_b <= r_qc;
            r_row_b <= r_qr;
        end
        if (i_cmd.set_acc) r_acc <= 1'b1;
        if (i_cmd.uop_ex && i_cmd.uop.kind == K_RDF) begin
            r_accs <= r_dq;
            if (i_cmd.uop.tot_clr) begin
                r_before <= r_tot;
                r_tot    <= '0;
            end
        end
        if (i_cmd.uop_ex && i_cmd.uop.kind == K_RDL) begin
            if (w_s < 12'd2) r_err <= 1'b1;
            r_tot <= r_tot + TOT_W'(w_conf);
            if (i_cmd.uop.cap_a) begin
                r_ca <= (w_conf > SUM_W'(CONF_SAT)) ? CONF_SAT : w_conf[CONF_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.accepted    <= r_acc;
            r_out.conflicts_a <= r_ca;
            r_out.solved      <= (r_free == w_full);
            r_out.error       <= r_err;
        end
    end

    assign o_stat.func       = i_in_data.func;
    assign o_stat.sweep_last = (r_sw == DW'(DIAGS - 1));
    assign o_stat.revert     = (r_tot > r_before);
    assign o_stat.out_free   = !r_oval || i_out_ready;

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- rtl/qsce_ctrl.sv -----
// Controller: sequences clear sweeps, queen reads and the diagonal micro-program.
`default_nettype none
module qsce_ctrl import qsce_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    output logic   o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SWEEP, S_PLACE, S_QA, S_QB, S_QL,
        S_RUN, S_DEC, S_WA, S_WB, S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_phase, n_phase;
    logic              r_swap, n_swap;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_phase = r_phase;
        n_swap  = r_swap;
        o_cmd     = '0;
        o_cmd.uop = uop_get(r_swap, r_step);
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.free_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    case (i_stat.func)
                        FN_CLEAR: n_state = S_SWEEP;
                        FN_PLACE: n_state = S_PLACE;
                        FN_SWAP:  n_state = S_QA;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.free_load = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_PLACE: begin
                o_cmd.place_wr = 1'b1;
                n_step  = '0;
                n_phase = 1'b0;
                n_swap  = 1'b0;
                n_state = S_RUN;
            end
            S_QA: begin
                o_cmd.q_rd = 1'b1;
                n_state = S_QB;
            end
            S_QB: begin
                o_cmd.q_rd    = 1'b1;
                o_cmd.q_sel_b = 1'b1;
                o_cmd.q_cap_a = 1'b1;
                n_state = S_QL;
            end
            S_QL: begin
                o_cmd.q_cap_b = 1'b1;
                n_step  = '0;
                n_phase = 1'b0;
                n_swap  = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (!r_phase) begin
                    o_cmd.uop_rd = 1'b1;
                    n_phase = 1'b1;
                end else begin
                    o_cmd.uop_ex = 1'b1;
                    n_phase = 1'b0;
                    n_step  = r_step + 1'b1;
                    if (r_swap && r_step == SWAP_DEC) begin
                        n_state = S_DEC;
                    end else if (r_swap && r_step == SWAP_LAST) begin
                        n_state = S_DONE;
                    end else if (!r_swap && r_step == PLACE_LAST) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DEC: begin
                if (i_stat.revert) begin
                    n_state = S_RUN;
                end else begin
                    o_cmd.set_acc = 1'b1;
                    n_state = S_WA;
                end
            end
            S_WA: begin
                o_cmd.row_wr_a = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.row_wr_b = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_step  <= '0;
            r_phase <= 1'b0;
            r_swap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_swap  <= n_swap;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/queen_swap_conflict_engine_top.sv -----
// Top level of the queen swap conflict engine: controller plus datapath.
// One beat in flight; input ready returns as the result beat is loaded.
// Each diagonal update is a read phase then a write phase on the counter memory.
// Reset (synchronous, active low) zeroes all 4*MAX_QUEENS counters in a sweep with
// no beat accepted; board size resets to 8. MAX_QUEENS must be a power of two;
// the block does not check it.
`default_nettype none
module queen_swap_conflict_engine_top import qsce_pkg::*; #(
    parameter int MAX_QUEENS = MAX_QUEENS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_beat            i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output t_out_beat                o_out_data,
    input  wire                      i_cfg_we,
    input  wire logic [BOARD_W-1:0]  i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    qsce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    qsce_dp #(
        .MAX_QUEENS (MAX_QUEENS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
